>>> rtl/scba_pkg.sv
// Shared constants, payload types and elaboration-time table functions.
`timescale 1ns / 1ps
`default_nettype none

package scba_pkg;

    localparam int BLOCK_LEN    = 10;
    localparam int ADC_BITS     = 10;
    localparam int SERIES_OHMS  = 4550;
    localparam int NOMINAL_OHMS = 2480;
    localparam int BETA_K       = 3480;

    localparam int GAIN_W    = 16;
    localparam int OUT_W     = 16;
    localparam int TEMP_W    = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CNT_W     = $clog2(BLOCK_LEN);
    localparam int MV_W      = ADC_BITS + GAIN_W - 8;
    localparam int SUM_W     = MV_W + CNT_W;
    localparam int TSUM_W    = TEMP_W + CNT_W;
    localparam int ROM_DEPTH = 1 << ADC_BITS;

    // Divide by BLOCK_LEN as multiply by ceil(2^k / BLOCK_LEN), exact below 2^SUM_W
    localparam int DIV_SHIFT = SUM_W + CNT_W;
    localparam int RECIP_W   = SUM_W + 2;
    localparam int PROD_W    = SUM_W + RECIP_W;
    localparam longint unsigned RECIP =
        ((64'd1 << DIV_SHIFT) + 64'(BLOCK_LEN) - 64'd1) / 64'(BLOCK_LEN);
    localparam logic [RECIP_W-1:0] RECIP_V = RECIP_W'(RECIP);

    localparam logic [OUT_W-1:0] OUT_MAX = '1;

    localparam int TEMP_MIN  = -5000;
    localparam int TEMP_MAX  = 25000;
    localparam int T0_CK     = 29315;
    localparam int ZERO_C_CK = 27315;
    localparam longint unsigned LN2_Q30 = 64'd744261118;

    localparam logic [GAIN_W-1:0] VOLTAGE_GAIN_RST    = 16'd6975;
    localparam logic [GAIN_W-1:0] PRESSURE_GAIN_RST   = 16'd3128;
    localparam logic [GAIN_W-1:0] PRESSURE_OFFSET_RST = 16'd1250;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_VOLTAGE_GAIN    = 2'd0,
        REG_PRESSURE_GAIN   = 2'd1,
        REG_PRESSURE_OFFSET = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [ADC_BITS-1:0] battery_code;
        logic [ADC_BITS-1:0] pressure_code;
        logic [ADC_BITS-1:0] thermistor_code;
    } in_item_t;

    typedef struct packed {
        logic [OUT_W-1:0]         avg_battery_mv;
        logic [OUT_W-1:0]         avg_pressure_mbar;
        logic signed [TEMP_W-1:0] avg_temp_cdeg;
    } out_item_t;

    typedef struct packed {
        logic [GAIN_W-1:0] voltage_gain_q8;
        logic [GAIN_W-1:0] pressure_gain_q8;
        logic [GAIN_W-1:0] pressure_offset_mbar;
    } cfg_t;

    typedef struct packed {
        logic [MV_W-1:0]          battery_mv;
        logic [MV_W-1:0]          pressure_mbar;
        logic signed [TEMP_W-1:0] temp_cdeg;
    } conv_t;

    typedef struct packed {
        logic [SUM_W-1:0]  battery_sum;
        logic [SUM_W-1:0]  pressure_sum;
        logic              temp_neg;
        logic [TSUM_W-1:0] temp_mag;
    } blk_t;

    // Q24 log2: msb position as integer part, fraction by repeated squaring
    function automatic logic [31:0] log2_q24(input logic [63:0] x);
        logic [5:0]  n;
        logic [63:0] m;
        logic [23:0] frac;
        n    = '0;
        m    = '0;
        frac = '0;
        if (x == 64'd0)
        begin
            return 32'd0;
        end
        for (int i = 1; i < 64; i++)
        begin
            if ((x >> i) != 64'd0)
            begin
                n = 6'(i);
            end
        end
        if (n >= 6'd30)
        begin
            m = x >> (n - 6'd30);
        end
        else
        begin
            m = x << (6'd30 - n);
        end
        for (int i = 0; i < 24; i++)
        begin
            m    = (m * m) >> 30;
            frac = {frac[22:0], 1'b0};
            if (m >= (64'd1 << 31))
            begin
                m       = m >> 1;
                frac[0] = 1'b1;
            end
        end
        return {2'b00, n, frac};
    endfunction

    // Restoring long division, used only while building the table
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int i = 63; i >= 0; i--)
        begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den})
            begin
                rem    = rem - {1'b0, den};
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // NTC beta equation in centidegrees, rounded half up and clamped
    function automatic logic signed [TEMP_W-1:0] temp_of_code(input int unsigned code);
        longint unsigned full;
        longint unsigned x;
        longint unsigned y;
        longint unsigned mag;
        longint unsigned lnm;
        longint unsigned num;
        longint unsigned tck;
        longint          l;
        longint          ln;
        longint          d;
        full = (64'd1 << ADC_BITS) - 64'd1;
        if (code == 0 || 64'(code) >= full)
        begin
            return TEMP_W'(TEMP_MIN);
        end
        x   = 64'(SERIES_OHMS) * 64'(code);
        y   = 64'(NOMINAL_OHMS) * (full - 64'(code));
        l   = longint'({32'd0, log2_q24(x)}) - longint'({32'd0, log2_q24(y)});
        mag = (l < 0) ? $unsigned(-l) : $unsigned(l);
        lnm = (mag * LN2_Q30 + (64'd1 << 29)) >> 30;
        ln  = (l < 0) ? -$signed(lnm) : $signed(lnm);
        d   = ln * longint'(T0_CK) + (longint'(100 * BETA_K) <<< 24);
        if (d <= 0)
        begin
            return TEMP_W'(TEMP_MIN);
        end
        num = (64'(100 * BETA_K) * 64'(T0_CK)) << 24;
        tck = udiv64(64'd2 * num + $unsigned(d), 64'd2 * $unsigned(d));
        if (tck > 64'(ZERO_C_CK + TEMP_MAX))
        begin
            return TEMP_W'(TEMP_MAX);
        end
        if ($signed(tck) - longint'(ZERO_C_CK) < longint'(TEMP_MIN))
        begin
            return TEMP_W'(TEMP_MIN);
        end
        return TEMP_W'($signed(tck) - longint'(ZERO_C_CK));
    endfunction

endpackage

`default_nettype wire

>>> rtl/scba_temp_rom.sv
// Thermistor code to centidegree ROM with registered read.
`timescale 1ns / 1ps
`default_nettype none

module scba_temp_rom (
    input  logic                                 clk,
    input  logic                                 en,
    input  logic [scba_pkg::ADC_BITS-1:0]        addr,
    output logic signed [scba_pkg::TEMP_W-1:0]   data
);
    import scba_pkg::*;

    logic signed [TEMP_W-1:0] rom_table [ROM_DEPTH];
    logic signed [TEMP_W-1:0] data_reg;

    for (genvar g = 0; g < ROM_DEPTH; g++)
    begin : g_rom
        localparam logic signed [TEMP_W-1:0] ENTRY = temp_of_code(g);
        assign rom_table[g] = ENTRY;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= rom_table[addr];
        end
    end

    assign data = data_reg;

endmodule

`default_nettype wire

>>> rtl/scba_convert.sv
// Per-item conversion stage: gain multiplies, pressure offset and temperature lookup.
`timescale 1ns / 1ps
`default_nettype none

module scba_convert (
    input  logic               clk,
    input  logic               rst_n,
    input  scba_pkg::cfg_t     cfg,
    input  logic               in_valid,
    output logic               in_ready,
    input  scba_pkg::in_item_t in_item,
    input  logic               take,
    output logic               conv_valid,
    output scba_pkg::conv_t    conv
);
    import scba_pkg::*;

    logic                           valid_reg;
    logic                           valid_next;
    logic                           load;
    logic [MV_W-1:0]                mv_reg;
    logic [MV_W-1:0]                mv_next;
    logic [MV_W-1:0]                mbar_reg;
    logic [MV_W-1:0]                mbar_next;
    logic [ADC_BITS+GAIN_W-1:0]     bat_prod;
    logic [ADC_BITS+GAIN_W-1:0]     prs_prod;
    logic [MV_W-1:0]                prs_raw;
    logic signed [TEMP_W-1:0]       temp_cdeg;

    assign in_ready = !valid_reg || take;
    assign load     = in_valid && in_ready;

    scba_temp_rom u_temp_rom (
        .clk  (clk),
        .en   (load),
        .addr (in_item.thermistor_code),
        .data (temp_cdeg)
    );

    always_comb
    begin
        bat_prod = {{GAIN_W{1'b0}}, in_item.battery_code}
                 * {{ADC_BITS{1'b0}}, cfg.voltage_gain_q8};
        prs_prod = {{GAIN_W{1'b0}}, in_item.pressure_code}
                 * {{ADC_BITS{1'b0}}, cfg.pressure_gain_q8};
        mv_next  = bat_prod[ADC_BITS+GAIN_W-1:8];
        prs_raw  = prs_prod[ADC_BITS+GAIN_W-1:8];
        // clamp at zero below the sensor offset
        if (prs_raw > MV_W'(cfg.pressure_offset_mbar))
        begin
            mbar_next = prs_raw - MV_W'(cfg.pressure_offset_mbar);
        end
        else
        begin
            mbar_next = '0;
        end
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            mv_reg   <= mv_next;
            mbar_reg <= mbar_next;
        end
    end

    assign conv_valid         = valid_reg;
    assign conv.battery_mv    = mv_reg;
    assign conv.pressure_mbar = mbar_reg;
    assign conv.temp_cdeg     = temp_cdeg;

    a_hold_until_taken: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !take |=> valid_reg)
        else $error("converted item dropped before transfer to accumulator");

    a_temp_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (temp_cdeg >= TEMP_W'(TEMP_MIN) && temp_cdeg <= TEMP_W'(TEMP_MAX)))
        else $error("temperature lookup out of range");

endmodule

`default_nettype wire

>>> rtl/scba_accum.sv
// Block accumulator: running sums, sample counter and completed-block register.
`timescale 1ns / 1ps
`default_nettype none

module scba_accum (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            conv_valid,
    input  scba_pkg::conv_t conv,
    output logic            take,
    input  logic            blk_take,
    output logic            blk_valid,
    output scba_pkg::blk_t  blk
);
    import scba_pkg::*;

    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic [SUM_W-1:0]         bat_reg;
    logic [SUM_W-1:0]         bat_next;
    logic [SUM_W-1:0]         prs_reg;
    logic [SUM_W-1:0]         prs_next;
    logic signed [TSUM_W-1:0] tsum_reg;
    logic signed [TSUM_W-1:0] tsum_next;
    logic                     blk_valid_reg;
    logic                     blk_valid_next;
    blk_t                     blk_reg;
    blk_t                     blk_next;
    logic                     last;
    logic [SUM_W-1:0]         bat_add;
    logic [SUM_W-1:0]         prs_add;
    logic signed [TSUM_W-1:0] tsum_add;

    assign last = (count_reg == CNT_W'(BLOCK_LEN - 1));
    // closing item waits only while the previous block is still held
    assign take = conv_valid && (!last || !blk_valid_reg);

    always_comb
    begin
        bat_add  = bat_reg + SUM_W'(conv.battery_mv);
        prs_add  = prs_reg + SUM_W'(conv.pressure_mbar);
        tsum_add = tsum_reg + TSUM_W'(conv.temp_cdeg);

        count_next     = count_reg;
        bat_next       = bat_reg;
        prs_next       = prs_reg;
        tsum_next      = tsum_reg;
        blk_valid_next = blk_valid_reg && !blk_take;
        blk_next       = blk_reg;

        if (take)
        begin
            if (last)
            begin
                count_next            = '0;
                bat_next              = '0;
                prs_next              = '0;
                tsum_next             = '0;
                blk_valid_next        = 1'b1;
                blk_next.battery_sum  = bat_add;
                blk_next.pressure_sum = prs_add;
                blk_next.temp_neg     = tsum_add[TSUM_W-1];
                blk_next.temp_mag     = tsum_add[TSUM_W-1] ? $unsigned(-tsum_add)
                                                            : $unsigned(tsum_add);
            end
            else
            begin
                count_next = count_reg + CNT_W'(1);
                bat_next   = bat_add;
                prs_next   = prs_add;
                tsum_next  = tsum_add;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            bat_reg       <= '0;
            prs_reg       <= '0;
            tsum_reg      <= '0;
            blk_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            bat_reg       <= bat_next;
            prs_reg       <= prs_next;
            tsum_reg      <= tsum_next;
            blk_valid_reg <= blk_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        blk_reg <= blk_next;
    end

    assign blk_valid = blk_valid_reg;
    assign blk       = blk_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(BLOCK_LEN - 1))
        else $error("sample counter past block length");

    a_block_close: assert property (@(posedge clk) disable iff (!rst_n)
        take && last |=> blk_valid_reg && count_reg == '0 && bat_reg == '0)
        else $error("block close did not hand off sums and restart");

endmodule

`default_nettype wire

>>> rtl/sensor_convert_block_average.sv
// Top level: configuration registers, conversion, accumulation and averaging output stage.
// Takes one item per cycle while in_ready is high. The result for each block of BLOCK_LEN
// items passes from the last item's transfer through the conversion register, which holds
// the gain multiplies and the temperature ROM read, the block register after accumulation,
// and the output register after the divide by BLOCK_LEN (a constant reciprocal multiply).
// in_ready drops only when a finished block is held in both the block register and the
// output register and another block closes. The 1024-entry temperature ROM is built at
// elaboration. Configuration writes take effect at once and are meant for idle periods.
`timescale 1ns / 1ps
`default_nettype none

module sensor_convert_block_average (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [scba_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [scba_pkg::GAIN_W-1:0]        cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  scba_pkg::in_item_t                 in_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output scba_pkg::out_item_t                out_data
);
    import scba_pkg::*;

    cfg_t              cfg_reg;
    cfg_t              cfg_next;
    logic              conv_valid;
    conv_t             conv;
    logic              take;
    logic              blk_valid;
    blk_t              blk;
    logic              out_load;
    logic              out_valid_reg;
    logic              out_valid_next;
    out_item_t         out_reg;
    out_item_t         out_next;
    logic [PROD_W-1:0] bat_prod;
    logic [PROD_W-1:0] prs_prod;
    logic [PROD_W-1:0] tmp_prod;
    logic [SUM_W-1:0]  bat_q;
    logic [SUM_W-1:0]  prs_q;
    logic [SUM_W-1:0]  tmp_q;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_VOLTAGE_GAIN:    cfg_next.voltage_gain_q8      = cfg_data;
                REG_PRESSURE_GAIN:   cfg_next.pressure_gain_q8     = cfg_data;
                REG_PRESSURE_OFFSET: cfg_next.pressure_offset_mbar = cfg_data;
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.voltage_gain_q8      <= VOLTAGE_GAIN_RST;
            cfg_reg.pressure_gain_q8     <= PRESSURE_GAIN_RST;
            cfg_reg.pressure_offset_mbar <= PRESSURE_OFFSET_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    scba_convert u_convert (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_data),
        .take       (take),
        .conv_valid (conv_valid),
        .conv       (conv)
    );

    scba_accum u_accum (
        .clk        (clk),
        .rst_n      (rst_n),
        .conv_valid (conv_valid),
        .conv       (conv),
        .take       (take),
        .blk_take   (out_load),
        .blk_valid  (blk_valid),
        .blk        (blk)
    );

    assign out_load = blk_valid && (!out_valid_reg || out_ready);

    always_comb
    begin
        bat_prod = {{RECIP_W{1'b0}}, blk.battery_sum} * {{SUM_W{1'b0}}, RECIP_V};
        prs_prod = {{RECIP_W{1'b0}}, blk.pressure_sum} * {{SUM_W{1'b0}}, RECIP_V};
        tmp_prod = {{(PROD_W-TSUM_W){1'b0}}, blk.temp_mag} * {{SUM_W{1'b0}}, RECIP_V};
        bat_q    = SUM_W'(bat_prod >> DIV_SHIFT);
        prs_q    = SUM_W'(prs_prod >> DIV_SHIFT);
        tmp_q    = SUM_W'(tmp_prod >> DIV_SHIFT);

        out_next.avg_battery_mv    = (bat_q > SUM_W'(OUT_MAX)) ? OUT_MAX : bat_q[OUT_W-1:0];
        out_next.avg_pressure_mbar = (prs_q > SUM_W'(OUT_MAX)) ? OUT_MAX : prs_q[OUT_W-1:0];
        // divide the magnitude, then restore the sign: truncates toward zero
        out_next.avg_temp_cdeg     = blk.temp_neg ? -TEMP_W'(tmp_q) : TEMP_W'(tmp_q);

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> out_valid_reg)
        else $error("completed block not presented on output");

    a_blk_held: assert property (@(posedge clk) disable iff (!rst_n)
        blk_valid && out_valid_reg && !out_ready |=> blk_valid)
        else $error("completed block lost while output stalled");

endmodule

`default_nettype wire
